// ===== hw/rtl/odvm_pkg.sv =====
// ----------------------------------------------------------------------------
// Omni drive velocity mixer package
// Widths, register codes, pipeline payload types and small helper functions
// shared by the mixer core and its arithmetic pipelines.
// ----------------------------------------------------------------------------
`default_nettype none

package odvm_pkg;

  localparam int SPEED_W      = 32;
  localparam int ANGLE_W      = 16;
  localparam int REG_W        = 31;
  localparam int CFG_IDX_W    = 3;
  localparam int ROOT_W       = 32;
  localparam int RAD_W        = 64;
  localparam int DIV_Q_W      = 32;
  localparam int DIV_D_W      = 33;
  localparam int DELTA_W      = 33;
  localparam int WIDE_W       = 34;
  localparam int CRD_W        = 34;
  localparam int CRD_Z_W      = 33;
  localparam int CORDIC_STEPS = 24;
  localparam int VEL_W        = 37;
  localparam int HALF_W       = 38;
  localparam int TURN_W       = 49;
  localparam int SUM_W        = 51;

  localparam logic signed [CRD_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [CRD_W-1:0] CORDIC_ONE  = 34'sd1073741824;
  localparam logic [29:0]             HALF_SQRT2  = 30'd759250125;

  localparam logic [REG_W-1:0] RST_MAX_SPEED = 31'd65536;
  localparam logic [REG_W-1:0] RST_MAX_TURN  = 31'd65536;
  localparam logic [REG_W-1:0] RST_LIN_STEP  = 31'd655;
  localparam logic [REG_W-1:0] RST_TURN_STEP = 31'd655;
  localparam logic [REG_W-1:0] RST_LEVER     = 31'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_SPEED = 3'd0,
    REG_MAX_TURN  = 3'd1,
    REG_LIN_STEP  = 3'd2,
    REG_TURN_STEP = 3'd3,
    REG_LEVER     = 3'd4
  } cfg_reg_t;

  typedef logic signed [SPEED_W-1:0] spd_t;
  typedef logic signed [DELTA_W-1:0] dlt_t;
  typedef logic signed [WIDE_W-1:0]  wide_t;

  typedef struct packed {
    spd_t             tx;
    spd_t             ty;
    spd_t             tw;
    spd_t             mx;
    spd_t             my;
    spd_t             mw;
    logic [ANGLE_W-1:0] hd;
    logic             tflag;
  } side_a_t;

  typedef struct packed {
    side_a_t a;
    logic    sflag;
  } side_b_t;

  typedef struct packed {
    spd_t             mx;
    spd_t             my;
    spd_t             tw;
    spd_t             mw;
    spd_t             tx2;
    spd_t             ty2;
    logic [ANGLE_W-1:0] hd;
    logic             tflag;
    logic             sflag;
    dlt_t             dx;
    dlt_t             dy;
    logic             big;
  } side_d_t;

  typedef struct packed {
    logic             dxs;
    logic             dys;
    logic             lflag;
    spd_t             mx;
    spd_t             my;
    spd_t             tx2;
    spd_t             ty2;
    spd_t             tw;
    spd_t             mw;
    logic [ANGLE_W-1:0] hd;
    logic             tflag;
    logic             sflag;
  } side_e_t;

  typedef struct packed {
    wide_t tx;
    wide_t ty;
    wide_t tw;
    logic  tflag;
    logic  sflag;
  } side_f_t;

  function automatic logic [SPEED_W-1:0] mag32(input spd_t v);
    return v[SPEED_W-1] ? SPEED_W'(-v) : SPEED_W'(v);
  endfunction

  function automatic logic [DELTA_W-1:0] mag33(input dlt_t v);
    return v[DELTA_W-1] ? DELTA_W'(-v) : DELTA_W'(v);
  endfunction

  function automatic logic [SPEED_W-1:0] sat_speed(input logic signed [SUM_W-1:0] v);
    logic [SPEED_W-1:0] r;
    if (v > 51'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -51'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[SPEED_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [29:0] atan_turn(input int unsigned idx);
    logic [29:0] r;
    case (idx)
      0:  r = 30'd536870912;
      1:  r = 30'd316933406;
      2:  r = 30'd167458907;
      3:  r = 30'd85004756;
      4:  r = 30'd42667331;
      5:  r = 30'd21354465;
      6:  r = 30'd10679838;
      7:  r = 30'd5340245;
      8:  r = 30'd2670163;
      9:  r = 30'd1335087;
      10: r = 30'd667543;
      11: r = 30'd333772;
      12: r = 30'd166886;
      13: r = 30'd83443;
      14: r = 30'd41722;
      15: r = 30'd20861;
      16: r = 30'd10430;
      17: r = 30'd5215;
      18: r = 30'd2608;
      19: r = 30'd1304;
      20: r = 30'd652;
      21: r = 30'd326;
      22: r = 30'd163;
      23: r = 30'd81;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/odvm_isqrt.sv =====
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root of a 64-bit radicand, one result bit per stage, with a
// side payload that travels alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module odvm_isqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [odvm_pkg::RAD_W-1:0]    radicand,
  input  logic [SIDE_W-1:0]             in_side,
  output logic                          out_valid,
  output logic [odvm_pkg::ROOT_W-1:0]   root,
  output logic [SIDE_W-1:0]             out_side
);
  import odvm_pkg::*;

  logic [ROOT_W-1:0] vld_q;
  logic [RAD_W-1:0]  rem_q [ROOT_W];
  logic [RAD_W-1:0]  rt_q  [ROOT_W];
  logic [SIDE_W-1:0] side_q [ROOT_W];
  logic [RAD_W-1:0]  rem_in [ROOT_W];
  logic [RAD_W-1:0]  rt_in  [ROOT_W];
  logic [SIDE_W-1:0] side_in [ROOT_W];
  logic [RAD_W-1:0]  trial [ROOT_W];

  always_comb begin
    rem_in[0]  = radicand;
    rt_in[0]   = '0;
    side_in[0] = in_side;
    for (int k = 1; k < ROOT_W; k++) begin
      rem_in[k]  = rem_q[k-1];
      rt_in[k]   = rt_q[k-1];
      side_in[k] = side_q[k-1];
    end
    for (int k = 0; k < ROOT_W; k++) begin
      trial[k] = rt_in[k] + (RAD_W'(1) << (2 * (ROOT_W - 1 - k)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[ROOT_W-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < ROOT_W; k++) begin
        if (rem_in[k] >= trial[k]) begin
          rem_q[k] <= rem_in[k] - trial[k];
          rt_q[k]  <= (rt_in[k] >> 1) + (RAD_W'(1) << (2 * (ROOT_W - 1 - k)));
        end else begin
          rem_q[k] <= rem_in[k];
          rt_q[k]  <= rt_in[k] >> 1;
        end
        side_q[k] <= side_in[k];
      end
    end
  end

  assign out_valid = vld_q[ROOT_W-1];
  assign root      = rt_q[ROOT_W-1][ROOT_W-1:0];
  assign out_side  = side_q[ROOT_W-1];

endmodule

`default_nettype wire

// ===== hw/rtl/odvm_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined dual restoring divider
// Divides two 64-bit numerators by one shared 33-bit divisor, one quotient
// bit per stage, for quotients known to fit in 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module odvm_div #(
  parameter int SIDE_W = 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [odvm_pkg::RAD_W-1:0]     num_a,
  input  logic [odvm_pkg::RAD_W-1:0]     num_b,
  input  logic [odvm_pkg::DIV_D_W-1:0]   den,
  input  logic [SIDE_W-1:0]              in_side,
  output logic                           out_valid,
  output logic [odvm_pkg::DIV_Q_W-1:0]   quot_a,
  output logic [odvm_pkg::DIV_Q_W-1:0]   quot_b,
  output logic [SIDE_W-1:0]              out_side
);
  import odvm_pkg::*;

  logic [DIV_Q_W-1:0] vld_q;
  logic [RAD_W-1:0]   na_q [DIV_Q_W];
  logic [RAD_W-1:0]   nb_q [DIV_Q_W];
  logic [DIV_Q_W-1:0] qa_q [DIV_Q_W];
  logic [DIV_Q_W-1:0] qb_q [DIV_Q_W];
  logic [DIV_D_W-1:0] d_q  [DIV_Q_W];
  logic [SIDE_W-1:0]  side_q [DIV_Q_W];
  logic [RAD_W-1:0]   na_in [DIV_Q_W];
  logic [RAD_W-1:0]   nb_in [DIV_Q_W];
  logic [DIV_Q_W-1:0] qa_in [DIV_Q_W];
  logic [DIV_Q_W-1:0] qb_in [DIV_Q_W];
  logic [DIV_D_W-1:0] d_in  [DIV_Q_W];
  logic [SIDE_W-1:0]  side_in [DIV_Q_W];
  logic [RAD_W:0]     dsh [DIV_Q_W];

  always_comb begin
    na_in[0]   = num_a;
    nb_in[0]   = num_b;
    qa_in[0]   = '0;
    qb_in[0]   = '0;
    d_in[0]    = den;
    side_in[0] = in_side;
    for (int k = 1; k < DIV_Q_W; k++) begin
      na_in[k]   = na_q[k-1];
      nb_in[k]   = nb_q[k-1];
      qa_in[k]   = qa_q[k-1];
      qb_in[k]   = qb_q[k-1];
      d_in[k]    = d_q[k-1];
      side_in[k] = side_q[k-1];
    end
    for (int k = 0; k < DIV_Q_W; k++) begin
      dsh[k] = (RAD_W + 1)'(d_in[k]) << (DIV_Q_W - 1 - k);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[DIV_Q_W-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_Q_W; k++) begin
        if ({1'b0, na_in[k]} >= dsh[k]) begin
          na_q[k] <= na_in[k] - dsh[k][RAD_W-1:0];
          qa_q[k] <= qa_in[k] | (DIV_Q_W'(1) << (DIV_Q_W - 1 - k));
        end else begin
          na_q[k] <= na_in[k];
          qa_q[k] <= qa_in[k];
        end
        if ({1'b0, nb_in[k]} >= dsh[k]) begin
          nb_q[k] <= nb_in[k] - dsh[k][RAD_W-1:0];
          qb_q[k] <= qb_in[k] | (DIV_Q_W'(1) << (DIV_Q_W - 1 - k));
        end else begin
          nb_q[k] <= nb_in[k];
          qb_q[k] <= qb_in[k];
        end
        d_q[k]    <= d_in[k];
        side_q[k] <= side_in[k];
      end
    end
  end

  assign out_valid = vld_q[DIV_Q_W-1];
  assign quot_a    = qa_q[DIV_Q_W-1];
  assign quot_b    = qb_q[DIV_Q_W-1];
  assign out_side  = side_q[DIV_Q_W-1];

endmodule

`default_nettype wire

// ===== hw/rtl/odvm_cordic.sv =====
// ----------------------------------------------------------------------------
// Pipelined CORDIC sine and cosine
// Rotation-mode CORDIC in Q4.30 with Q2.30 outputs, over the heading in its
// quarter turn, one rotation per stage, then a clamp and quadrant swap stage.
// ----------------------------------------------------------------------------
`default_nettype none

module odvm_cordic #(
  parameter int SIDE_W = 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [odvm_pkg::ANGLE_W-1:0]   heading,
  input  logic [SIDE_W-1:0]              in_side,
  output logic                           out_valid,
  output logic signed [odvm_pkg::SPEED_W-1:0] cos_out,
  output logic signed [odvm_pkg::SPEED_W-1:0] sin_out,
  output logic [SIDE_W-1:0]              out_side
);
  import odvm_pkg::*;

  localparam int N = CORDIC_STEPS;

  logic [N:0]                vld_q;
  logic signed [CRD_W-1:0]   x_q [N];
  logic signed [CRD_W-1:0]   y_q [N];
  logic signed [CRD_Z_W-1:0] z_q [N];
  logic [1:0]                quad_q [N];
  logic [SIDE_W-1:0]         side_q [N];
  logic signed [CRD_W-1:0]   x_in [N];
  logic signed [CRD_W-1:0]   y_in [N];
  logic signed [CRD_Z_W-1:0] z_in [N];
  logic [1:0]                quad_in [N];
  logic [SIDE_W-1:0]         side_in [N];
  logic [31:0]               angle;
  logic signed [CRD_W-1:0]   xc;
  logic signed [CRD_W-1:0]   yc;
  logic signed [SPEED_W-1:0] cs_q;
  logic signed [SPEED_W-1:0] sn_q;
  logic [SIDE_W-1:0]         side_o;

  always_comb begin
    angle      = {heading, {(32 - ANGLE_W){1'b0}}};
    x_in[0]    = CORDIC_GAIN;
    y_in[0]    = '0;
    z_in[0]    = $signed({3'b000, angle[29:0]});
    quad_in[0] = angle[31:30];
    side_in[0] = in_side;
    for (int k = 1; k < N; k++) begin
      x_in[k]    = x_q[k-1];
      y_in[k]    = y_q[k-1];
      z_in[k]    = z_q[k-1];
      quad_in[k] = quad_q[k-1];
      side_in[k] = side_q[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[N-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        if (!z_in[k][CRD_Z_W-1]) begin
          x_q[k] <= x_in[k] - (y_in[k] >>> k);
          y_q[k] <= y_in[k] + (x_in[k] >>> k);
          z_q[k] <= z_in[k] - $signed({3'b000, atan_turn(k)});
        end else begin
          x_q[k] <= x_in[k] + (y_in[k] >>> k);
          y_q[k] <= y_in[k] - (x_in[k] >>> k);
          z_q[k] <= z_in[k] + $signed({3'b000, atan_turn(k)});
        end
        quad_q[k] <= quad_in[k];
        side_q[k] <= side_in[k];
      end
    end
  end

  always_comb begin
    if (x_q[N-1] > CORDIC_ONE) begin
      xc = CORDIC_ONE;
    end else if (x_q[N-1] < -CORDIC_ONE) begin
      xc = -CORDIC_ONE;
    end else begin
      xc = x_q[N-1];
    end
    if (y_q[N-1] > CORDIC_ONE) begin
      yc = CORDIC_ONE;
    end else if (y_q[N-1] < -CORDIC_ONE) begin
      yc = -CORDIC_ONE;
    end else begin
      yc = y_q[N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      case (quad_q[N-1])
        2'd0: begin
          cs_q <= SPEED_W'(xc);
          sn_q <= SPEED_W'(yc);
        end
        2'd1: begin
          cs_q <= SPEED_W'(-yc);
          sn_q <= SPEED_W'(xc);
        end
        2'd2: begin
          cs_q <= SPEED_W'(-xc);
          sn_q <= SPEED_W'(-yc);
        end
        default: begin
          cs_q <= SPEED_W'(yc);
          sn_q <= SPEED_W'(-xc);
        end
      endcase
      side_o <= side_q[N-1];
    end
  end

  assign out_valid = vld_q[N];
  assign cos_out   = cs_q;
  assign sin_out   = sn_q;
  assign out_side  = side_o;

endmodule

`default_nettype wire

// ===== hw/rtl/omni_drive_velocity_mixer_core.sv =====
// ----------------------------------------------------------------------------
// Omni drive velocity mixer core
// Speed and turn clamping, per-tick change limiting, field-to-body rotation
// and four-wheel 45-degree omni mixing as one stream pipeline.
// ----------------------------------------------------------------------------
// The core accepts one command transaction every clock while the output is not
// stalled and returns one wheel transaction per command, in order. Its path
// runs through two 32-stage square root pipelines, two 32-stage divider
// pipelines and a 25-stage CORDIC. A stall on the output holds the whole
// pipeline.
`default_nettype none

module omni_drive_velocity_mixer_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // request_vx, request_vy, request_turn, measured_vx, measured_vy,
  // measured_turn, heading
  input  logic [207:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // wheel_speed_a, wheel_speed_b, wheel_speed_c, wheel_speed_d,
  // speed_clamped, turn_clamped, zero padding
  output logic [135:0] m_tdata,
  input  logic         cfg_we,
  input  logic [odvm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [odvm_pkg::REG_W-1:0]     cfg_data
);
  import odvm_pkg::*;

  logic en;

  logic [REG_W-1:0] max_linear_speed;
  logic [REG_W-1:0] max_turn_rate;
  logic [REG_W-1:0] max_linear_step;
  logic [REG_W-1:0] max_turn_step;
  logic [REG_W-1:0] wheel_lever_radius;

  spd_t in_tw;
  spd_t maxw;
  spd_t tw_clamp;
  logic tflag_in;

  logic    v1;
  side_a_t s1;
  logic    v2;
  side_a_t s2;
  logic [RAD_W-1:0] sqx2;
  logic [RAD_W-1:0] sqy2;

  logic              va;
  logic [ROOT_W-1:0] root_a;
  side_a_t           sa;

  logic             v3;
  side_b_t          s3;
  logic [RAD_W-1:0] nx3;
  logic [RAD_W-1:0] ny3;
  logic [ROOT_W-1:0] r3;

  logic               vb;
  logic [DIV_Q_W-1:0] qa_b;
  logic [DIV_Q_W-1:0] qb_b;
  side_b_t            sb;

  spd_t              qx4;
  spd_t              qy4;
  spd_t              tx2;
  spd_t              ty2;
  dlt_t              dx4c;
  dlt_t              dy4c;
  logic [DELTA_W-1:0] ax4;
  logic [DELTA_W-1:0] ay4;
  logic              big4c;

  logic              v4;
  side_d_t           s4;
  logic [SPEED_W-1:0] hx4;
  logic [SPEED_W-1:0] hy4;

  logic             v5;
  side_d_t          s5;
  logic [RAD_W-1:0] sqx5;
  logic [RAD_W-1:0] sqy5;

  logic              vc;
  logic [ROOT_W-1:0] root_c;
  side_d_t           sc;
  logic [DIV_D_W-1:0] dmag;

  logic              v6;
  side_e_t           s6;
  logic [RAD_W-1:0]  px6;
  logic [RAD_W-1:0]  py6;
  logic [DIV_D_W-1:0] dmag6;

  logic               vd;
  logic [DIV_Q_W-1:0] qa_d;
  logic [DIV_Q_W-1:0] qb_d;
  side_e_t            sd;

  wide_t  qx7;
  wide_t  qy7;
  dlt_t   dw7;
  dlt_t   stepw7;
  side_f_t s7c;
  logic    v7;
  side_f_t s7;
  logic [ANGLE_W-1:0] hd7;

  logic    ve;
  spd_t    cs_e;
  spd_t    sn_e;
  side_f_t se;

  logic                  v8;
  logic signed [65:0]    p1_8;
  logic signed [65:0]    p2_8;
  logic signed [65:0]    p3_8;
  logic signed [65:0]    p4_8;
  logic signed [64:0]    tp8;
  logic                  tflag8;
  logic                  sflag8;

  logic signed [66:0]     sumx9;
  logic signed [66:0]     sumy9;
  logic                   v9;
  logic signed [VEL_W-1:0] vx9;
  logic signed [VEL_W-1:0] vy9;
  logic signed [TURN_W-1:0] turn9;
  logic                   tflag9;
  logic                   sflag9;

  logic signed [67:0]      hpx;
  logic signed [67:0]      hpy;
  logic                    v10;
  logic signed [HALF_W-1:0] hx10;
  logic signed [HALF_W-1:0] hy10;
  logic signed [TURN_W-1:0] turn10;
  logic                    tflag10;
  logic                    sflag10;

  logic signed [SUM_W-1:0] ex;
  logic signed [SUM_W-1:0] ey;
  logic signed [SUM_W-1:0] et;
  logic                    v11;
  logic [SPEED_W-1:0]      wa11;
  logic [SPEED_W-1:0]      wb11;
  logic [SPEED_W-1:0]      wc11;
  logic [SPEED_W-1:0]      wd11;
  logic                    sflag11;
  logic                    tflag11;

  assign en       = !v11 || m_tready;
  assign s_tready = en && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_linear_speed   <= RST_MAX_SPEED;
      max_turn_rate      <= RST_MAX_TURN;
      max_linear_step    <= RST_LIN_STEP;
      max_turn_step      <= RST_TURN_STEP;
      wheel_lever_radius <= RST_LEVER;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_MAX_SPEED: max_linear_speed   <= cfg_data;
        REG_MAX_TURN:  max_turn_rate      <= cfg_data;
        REG_LIN_STEP:  max_linear_step    <= cfg_data;
        REG_TURN_STEP: max_turn_step      <= cfg_data;
        REG_LEVER:     wheel_lever_radius <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register with the turn rate clamp.
  always_comb begin
    in_tw    = s_tdata[95:64];
    maxw     = $signed({1'b0, max_turn_rate});
    tflag_in = 1'b0;
    tw_clamp = in_tw;
    if (in_tw > maxw) begin
      tw_clamp = maxw;
      tflag_in = 1'b1;
    end else if (in_tw < -maxw) begin
      tw_clamp = -maxw;
      tflag_in = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1.tx    <= s_tdata[31:0];
      s1.ty    <= s_tdata[63:32];
      s1.tw    <= tw_clamp;
      s1.mx    <= s_tdata[127:96];
      s1.my    <= s_tdata[159:128];
      s1.mw    <= s_tdata[191:160];
      s1.hd    <= s_tdata[207:192];
      s1.tflag <= tflag_in;
      s2       <= s1;
      sqx2     <= RAD_W'(mag32(s1.tx)) * RAD_W'(mag32(s1.tx));
      sqy2     <= RAD_W'(mag32(s1.ty)) * RAD_W'(mag32(s1.ty));
    end
  end

  odvm_isqrt #(.SIDE_W($bits(side_a_t))) u_root_req (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v2),
    .radicand (sqx2 + sqy2),
    .in_side  (s2),
    .out_valid(va),
    .root     (root_a),
    .out_side (sa)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3.a     <= sa;
      s3.sflag <= root_a > {1'b0, max_linear_speed};
      nx3      <= RAD_W'(mag32(sa.tx)) * RAD_W'(max_linear_speed);
      ny3      <= RAD_W'(mag32(sa.ty)) * RAD_W'(max_linear_speed);
      r3       <= root_a;
    end
  end

  odvm_div #(.SIDE_W($bits(side_b_t))) u_div_speed (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v3),
    .num_a    (nx3),
    .num_b    (ny3),
    .den      ({1'b0, r3}),
    .in_side  (s3),
    .out_valid(vb),
    .quot_a   (qa_b),
    .quot_b   (qb_b),
    .out_side (sb)
  );

  // Apply the speed clamp and form the change from the measured velocity.
  always_comb begin
    qx4   = spd_t'(qa_b);
    qy4   = spd_t'(qb_b);
    tx2   = sb.a.tx;
    ty2   = sb.a.ty;
    if (sb.sflag) begin
      tx2 = sb.a.tx[SPEED_W-1] ? -qx4 : qx4;
      ty2 = sb.a.ty[SPEED_W-1] ? -qy4 : qy4;
    end
    dx4c  = dlt_t'(tx2) - dlt_t'(sb.a.mx);
    dy4c  = dlt_t'(ty2) - dlt_t'(sb.a.my);
    ax4   = mag33(dx4c);
    ay4   = mag33(dy4c);
    big4c = (|ax4[DELTA_W-1:DELTA_W-2]) || (|ay4[DELTA_W-1:DELTA_W-2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v4 <= vb;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4.mx    <= sb.a.mx;
      s4.my    <= sb.a.my;
      s4.tw    <= sb.a.tw;
      s4.mw    <= sb.a.mw;
      s4.tx2   <= tx2;
      s4.ty2   <= ty2;
      s4.hd    <= sb.a.hd;
      s4.tflag <= sb.a.tflag;
      s4.sflag <= sb.sflag;
      s4.dx    <= dx4c;
      s4.dy    <= dy4c;
      s4.big   <= big4c;
      hx4      <= big4c ? ax4[DELTA_W-1:1] : ax4[SPEED_W-1:0];
      hy4      <= big4c ? ay4[DELTA_W-1:1] : ay4[SPEED_W-1:0];
      s5       <= s4;
      sqx5     <= RAD_W'(hx4) * RAD_W'(hx4);
      sqy5     <= RAD_W'(hy4) * RAD_W'(hy4);
    end
  end

  odvm_isqrt #(.SIDE_W($bits(side_d_t))) u_root_delta (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v5),
    .radicand (sqx5 + sqy5),
    .in_side  (s5),
    .out_valid(vc),
    .root     (root_c),
    .out_side (sc)
  );

  assign dmag = sc.big ? {root_c, 1'b0} : {1'b0, root_c};

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6.dxs   <= sc.dx[DELTA_W-1];
      s6.dys   <= sc.dy[DELTA_W-1];
      s6.lflag <= dmag > {2'b00, max_linear_step};
      s6.mx    <= sc.mx;
      s6.my    <= sc.my;
      s6.tx2   <= sc.tx2;
      s6.ty2   <= sc.ty2;
      s6.tw    <= sc.tw;
      s6.mw    <= sc.mw;
      s6.hd    <= sc.hd;
      s6.tflag <= sc.tflag;
      s6.sflag <= sc.sflag;
      px6      <= RAD_W'(mag33(sc.dx)) * RAD_W'(max_linear_step);
      py6      <= RAD_W'(mag33(sc.dy)) * RAD_W'(max_linear_step);
      dmag6    <= dmag;
    end
  end

  odvm_div #(.SIDE_W($bits(side_e_t))) u_div_step (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v6),
    .num_a    (px6),
    .num_b    (py6),
    .den      (dmag6),
    .in_side  (s6),
    .out_valid(vd),
    .quot_a   (qa_d),
    .quot_b   (qb_d),
    .out_side (sd)
  );

  // Linear change limit and turn step limit.
  always_comb begin
    qx7       = wide_t'({2'b00, qa_d});
    qy7       = wide_t'({2'b00, qb_d});
    s7c.tx    = wide_t'(sd.tx2);
    s7c.ty    = wide_t'(sd.ty2);
    if (sd.lflag) begin
      s7c.tx = wide_t'(sd.mx) + (sd.dxs ? -qx7 : qx7);
      s7c.ty = wide_t'(sd.my) + (sd.dys ? -qy7 : qy7);
    end
    dw7       = dlt_t'(sd.tw) - dlt_t'(sd.mw);
    stepw7    = dlt_t'({2'b00, max_turn_step});
    s7c.tw    = wide_t'(sd.tw);
    if (dw7 > stepw7) begin
      s7c.tw = wide_t'(sd.mw) + wide_t'(stepw7);
    end else if (dw7 < -stepw7) begin
      s7c.tw = wide_t'(sd.mw) - wide_t'(stepw7);
    end
    s7c.tflag = sd.tflag;
    s7c.sflag = sd.sflag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7  <= s7c;
      hd7 <= sd.hd;
    end
  end

  odvm_cordic #(.SIDE_W($bits(side_f_t))) u_cordic (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v7),
    .heading  (hd7),
    .in_side  (s7),
    .out_valid(ve),
    .cos_out  (cs_e),
    .sin_out  (sn_e),
    .out_side (se)
  );

  always_comb begin
    sumx9 = 67'(p1_8) + 67'(p2_8);
    sumy9 = 67'(p3_8) - 67'(p4_8);
    hpx   = 68'($signed({1'b0, HALF_SQRT2})) * 68'(vx9);
    hpy   = 68'($signed({1'b0, HALF_SQRT2})) * 68'(vy9);
    ex    = SUM_W'(hx10);
    ey    = SUM_W'(hy10);
    et    = SUM_W'(turn10);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v8  <= 1'b0;
      v9  <= 1'b0;
      v10 <= 1'b0;
      v11 <= 1'b0;
    end else if (en) begin
      v8  <= ve;
      v9  <= v8;
      v10 <= v9;
      v11 <= v10;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_8    <= 66'(cs_e) * 66'(se.tx);
      p2_8    <= 66'(sn_e) * 66'(se.ty);
      p3_8    <= 66'(cs_e) * 66'(se.ty);
      p4_8    <= 66'(sn_e) * 66'(se.tx);
      tp8     <= 65'($signed({1'b0, wheel_lever_radius})) * 65'(se.tw);
      tflag8  <= se.tflag;
      sflag8  <= se.sflag;

      vx9     <= sumx9[66:30];
      vy9     <= sumy9[66:30];
      turn9   <= tp8[64:16];
      tflag9  <= tflag8;
      sflag9  <= sflag8;

      hx10    <= hpx[67:30];
      hy10    <= hpy[67:30];
      turn10  <= turn9;
      tflag10 <= tflag9;
      sflag10 <= sflag9;

      wa11    <= sat_speed(-ex + ey + et);
      wb11    <= sat_speed(-ex - ey + et);
      wc11    <= sat_speed(ex - ey + et);
      wd11    <= sat_speed(ex + ey + et);
      sflag11 <= sflag10;
      tflag11 <= tflag10;
    end
  end

  assign m_tvalid = v11;
  assign m_tdata  = {6'd0, tflag11, sflag11, wd11, wc11, wb11, wa11};

endmodule

`default_nettype wire
